### rtl/cbrm_pkg.sv
// ----------------------------------------------------------------------------
// cbrm_pkg
// Shared types and constants for the channel busy ratio meter.
// ----------------------------------------------------------------------------
package cbrm_pkg;

	localparam int RATIO_FRAC_BITS = 16;
	localparam int COUNTER_BITS    = 64;
	localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
	localparam int DIV_CNT_W       = $clog2(RATIO_FRAC_BITS);
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IGNORED     = 3'd0,
		ST_FIRST       = 3'd1,
		ST_WRAP        = 3'd2,
		ST_UPDATED     = 3'd3,
		ST_ZERO_ACTIVE = 3'd4
	} status_t;

	typedef struct packed {
		logic        in_use;
		logic [63:0] active_time;
		logic [63:0] busy_time;
		logic [63:0] receive_time;
		logic [63:0] transmit_time;
	} sample_t;

	typedef struct packed {
		status_t     status;
		logic        ratio_known;
		logic [16:0] busy_ratio;
		logic [63:0] busy_delta;
		logic [63:0] receive_delta;
		logic [63:0] transmit_delta;
	} result_t;

	typedef struct packed {
		logic    latch_sample;
		logic    clear_first;
		logic    load_base;
		logic    store_delta;
		logic    ratio_zero;
		logic    ratio_one;
		logic    div_init;
		logic    div_step;
		logic    div_last;
		logic    set_status;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic in_use;
		logic awaiting;
		logic wrap;
		logic da_zero;
		logic db_ge_da;
	} sts_t;

endpackage

### rtl/cbrm_ctrl.sv
// ----------------------------------------------------------------------------
// cbrm_ctrl
// Sequencer: evaluates a latched sample, runs the ratio divider and hands
// the result over.
// ----------------------------------------------------------------------------
module cbrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_ready,
	output logic           result_valid,
	input  logic           result_ready,
	input  cbrm_pkg::sts_t sts,
	output cbrm_pkg::cmd_t cmd
);
	import cbrm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 last_step;

	assign last_step    = (cnt_q == DIV_CNT_W'(RATIO_FRAC_BITS - 1));
	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = (state_q == S_OUT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_sample = sample_valid;
				if (sample_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.set_status = 1'b1;
				state_d        = S_OUT;
				if (!sts.in_use) begin
					cmd.status = ST_IGNORED;
				end else if (sts.awaiting) begin
					cmd.status      = ST_FIRST;
					cmd.clear_first = 1'b1;
					cmd.load_base   = 1'b1;
					cmd.ratio_zero  = 1'b1;
				end else if (sts.wrap) begin
					cmd.status    = ST_WRAP;
					cmd.load_base = 1'b1;
				end else begin
					cmd.load_base   = 1'b1;
					cmd.store_delta = 1'b1;
					if (sts.da_zero) begin
						cmd.status     = ST_ZERO_ACTIVE;
						cmd.ratio_zero = 1'b1;
					end else if (sts.db_ge_da) begin
						cmd.status    = ST_UPDATED;
						cmd.ratio_one = 1'b1;
					end else begin
						cmd.status   = ST_UPDATED;
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = last_step;
				if (last_step) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (result_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

endmodule

### rtl/cbrm_datapath.sv
// ----------------------------------------------------------------------------
// cbrm_datapath
// Sample latch, baselines, deltas, restoring ratio divider and stored results.
// ----------------------------------------------------------------------------
module cbrm_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cbrm_pkg::sample_t sample,
	input  cbrm_pkg::cmd_t    cmd,
	output cbrm_pkg::sts_t    sts,
	output cbrm_pkg::result_t result
);
	import cbrm_pkg::*;

	logic                       in_use_q;
	logic [COUNTER_BITS-1:0]    act_q, bsy_q, rcv_q, xmt_q;
	logic [COUNTER_BITS-1:0]    base_act_q, base_bsy_q, base_rcv_q, base_xmt_q;
	logic [COUNTER_BITS-1:0]    da, db, dr, dt;
	logic                       awaiting_q;
	logic [RATIO_W-1:0]         ratio_q;
	logic                       known_q;
	logic [COUNTER_BITS-1:0]    dbsy_q, drcv_q, dxmt_q;
	status_t                    status_q;
	logic [COUNTER_BITS-1:0]    rem_q, den_q, rem_next;
	logic [COUNTER_BITS:0]      shifted;
	logic                       take;
	logic [RATIO_FRAC_BITS-1:0] quo_q, quo_next;

	assign da = act_q - base_act_q;
	assign db = bsy_q - base_bsy_q;
	assign dr = rcv_q - base_rcv_q;
	assign dt = xmt_q - base_xmt_q;

	assign sts.in_use   = in_use_q;
	assign sts.awaiting = awaiting_q;
	assign sts.wrap     = (act_q < base_act_q) || (bsy_q < base_bsy_q) ||
	                      (rcv_q < base_rcv_q) || (xmt_q < base_xmt_q);
	assign sts.da_zero  = (da == '0);
	assign sts.db_ge_da = (db >= da);

	// one restoring step; the shifted-out top bit forces a subtract
	assign shifted  = {rem_q, 1'b0};
	assign take     = (shifted >= {1'b0, den_q});
	assign rem_next = take ? (shifted[COUNTER_BITS-1:0] - den_q) : shifted[COUNTER_BITS-1:0];
	assign quo_next = {quo_q[RATIO_FRAC_BITS-2:0], take};

	always_ff @(posedge clk) begin
		if (cmd.latch_sample) begin
			in_use_q <= sample.in_use;
			act_q    <= sample.active_time[COUNTER_BITS-1:0];
			bsy_q    <= sample.busy_time[COUNTER_BITS-1:0];
			rcv_q    <= sample.receive_time[COUNTER_BITS-1:0];
			xmt_q    <= sample.transmit_time[COUNTER_BITS-1:0];
		end
		if (cmd.div_init) begin
			rem_q <= db;
			den_q <= da;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			base_act_q <= '0;
			base_bsy_q <= '0;
			base_rcv_q <= '0;
			base_xmt_q <= '0;
			ratio_q    <= '0;
			known_q    <= 1'b0;
			dbsy_q     <= '0;
			drcv_q     <= '0;
			dxmt_q     <= '0;
			status_q   <= ST_IGNORED;
		end else begin
			if (cmd.clear_first) begin
				awaiting_q <= 1'b0;
			end
			if (cmd.load_base) begin
				base_act_q <= act_q;
				base_bsy_q <= bsy_q;
				base_rcv_q <= rcv_q;
				base_xmt_q <= xmt_q;
			end
			if (cmd.store_delta) begin
				dbsy_q <= db;
				drcv_q <= dr;
				dxmt_q <= dt;
			end
			if (cmd.ratio_zero) begin
				ratio_q <= '0;
				known_q <= 1'b0;
			end else if (cmd.ratio_one) begin
				ratio_q <= RATIO_ONE;
				known_q <= 1'b1;
			end else if (cmd.div_last) begin
				ratio_q <= RATIO_W'(quo_next);
				known_q <= 1'b1;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
		end
	end

	assign result.status         = status_q;
	assign result.ratio_known    = known_q;
	assign result.busy_ratio     = 17'(ratio_q);
	assign result.busy_delta     = 64'(dbsy_q);
	assign result.receive_delta  = 64'(drcv_q);
	assign result.transmit_delta = 64'(dxmt_q);

endmodule

### rtl/channel_busy_ratio_meter_core.sv
// ----------------------------------------------------------------------------
// channel_busy_ratio_meter_core
// Busy-over-active ratio from running survey counters, one item at a time.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes through EVAL to result_valid, and through DIV as well when
// the ratio is divided (16 iterations of the restoring divider, one quotient bit a cycle).
// No new item is taken while one is in flight; a new item is taken in the cycle
// after the result is taken.
// Reset: asynchronous; baselines and stored results clear, first-sample flag sets.
module channel_busy_ratio_meter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  cbrm_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output cbrm_pkg::result_t result
);
	import cbrm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cbrm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	cbrm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

### rtl/cbrm_checker.sv
// ----------------------------------------------------------------------------
// cbrm_checker
// Port-level checks for the busy ratio meter, bound to the top level.
// ----------------------------------------------------------------------------
module cbrm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              result_valid,
	input logic              result_ready,
	input cbrm_pkg::result_t result
);
	import cbrm_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_ready && result_valid))
		else $error("item taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("ready right after accepting an item");

	a_unknown_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_FIRST || result.status == ST_ZERO_ACTIVE)
		|-> !result.ratio_known && result.busy_ratio == '0)
		else $error("ratio must be unknown and zero");

	a_ratio_capped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_UPDATED
		|-> result.ratio_known && result.busy_ratio <= 17'(RATIO_ONE))
		else $error("updated ratio not known or above one");

endmodule

bind channel_busy_ratio_meter_core cbrm_checker u_cbrm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives survey samples into channel_busy_ratio_meter_core with random valid
// and ready bursts and one long output stall. A local model predicts status,
// ratio and deltas for each accepted item; results are checked in order.
// ----------------------------------------------------------------------------
module testbench;
	import cbrm_pkg::*;

	localparam int          N_LIVE     = 500;
	localparam int          TAIL_ITEMS = 60;
	localparam int          STALL_LEN  = 300;
	localparam int          DOG_LIMIT  = 5000;
	localparam int          DRAIN_CYC  = 40;
	localparam logic [63:0] ONES       = '1;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	sample_t pending_samples[$];
	result_t expected_results[$];

	// model state
	logic                meter_first;
	logic [63:0]         base_a, base_b, base_r, base_t;
	logic [RATIO_W-1:0]  held_ratio;
	logic                held_known;
	logic [63:0]         held_db, held_dr, held_dt;

	int   accepted_cnt = 0;
	int   mismatch_cnt = 0;
	int   err_cnt      = 0;
	logic quiet_tail   = 1'b0;
	int   send_gap     = 0;
	int   recv_gap     = 0;
	int   stall_cnt    = 0;
	logic stall_done   = 1'b0;
	int   dog_cnt      = 0;

	channel_busy_ratio_meter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic logic [RATIO_W-1:0] busy_fraction(logic [63:0] num, logic [63:0] den);
		logic [64:0]        rem;
		logic [RATIO_W-1:0] q;
		if (num >= den) begin
			return RATIO_ONE;
		end
		rem = {1'b0, num};
		q   = '0;
		for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic result_t predict_result(sample_t s);
		result_t     r;
		status_t     st;
		logic [63:0] da;
		if (!s.in_use) begin
			st = ST_IGNORED;
		end else if (meter_first) begin
			meter_first = 1'b0;
			held_ratio  = '0;
			held_known  = 1'b0;
			st          = ST_FIRST;
		end else if (s.active_time < base_a || s.busy_time < base_b ||
				s.receive_time < base_r || s.transmit_time < base_t) begin
			st = ST_WRAP;
		end else begin
			da = s.active_time - base_a;
			if (da != 0) begin
				held_ratio = busy_fraction(s.busy_time - base_b, da);
				held_known = 1'b1;
				st         = ST_UPDATED;
			end else begin
				held_ratio = '0;
				held_known = 1'b0;
				st         = ST_ZERO_ACTIVE;
			end
			held_db = s.busy_time - base_b;
			held_dr = s.receive_time - base_r;
			held_dt = s.transmit_time - base_t;
		end
		if (s.in_use) begin
			base_a = s.active_time;
			base_b = s.busy_time;
			base_r = s.receive_time;
			base_t = s.transmit_time;
		end
		r.status         = st;
		r.ratio_known    = held_known;
		r.busy_ratio     = held_ratio;
		r.busy_delta     = held_db;
		r.receive_delta  = held_dr;
		r.transmit_delta = held_dt;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_step();
		int w;
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 32);
		return rand64() >> (64 - w);
	endfunction

	task automatic queue_sample(input logic u, input logic [63:0] a, b, r, t);
		sample_t s;
		s.in_use        = u;
		s.active_time   = a;
		s.busy_time     = b;
		s.receive_time  = r;
		s.transmit_time = t;
		pending_samples.push_back(s);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			send_gap     <= 0;
			quiet_tail   <= 1'b0;
		end else begin
			quiet_tail <= (pending_samples.size() < TAIL_ITEMS);
			if (sample_valid && sample_ready) begin
				expected_results.push_back(predict_result(sample));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap     <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0 &&
						(quiet_tail || $urandom_range(0, 6) != 0)) begin
					sample       <= pending_samples.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
					if (!quiet_tail && pending_samples.size() > 0) begin
						send_gap <= $urandom_range(0, 4);
					end
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap     <= 0;
			stall_cnt    <= 0;
			stall_done   <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					err_cnt++;
					$display("unexpected item: status %0d ratio %0d", result.status,
						result.busy_ratio);
				end else begin
					e = expected_results.pop_front();
					if (result.status !== e.status || result.ratio_known !== e.ratio_known ||
							result.busy_ratio !== e.busy_ratio ||
							result.busy_delta !== e.busy_delta ||
							result.receive_delta !== e.receive_delta ||
							result.transmit_delta !== e.transmit_delta) begin
						err_cnt++;
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch: status exp %0d act %0d, known exp %0d act %0d",
								e.status, result.status, e.ratio_known, result.ratio_known);
							$display("  ratio exp %0d act %0d, busy_delta exp %h act %h",
								e.busy_ratio, result.busy_ratio, e.busy_delta,
								result.busy_delta);
							$display("  rx_delta exp %h act %h, tx_delta exp %h act %h",
								e.receive_delta, result.receive_delta,
								e.transmit_delta, result.transmit_delta);
						end
					end
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt    <= stall_cnt - 1;
				result_ready <= 1'b0;
			end else if (!stall_done && !quiet_tail && accepted_cnt >= 150) begin
				stall_cnt    <= STALL_LEN;
				stall_done   <= 1'b1;
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap     <= recv_gap - 1;
				result_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				recv_gap     <= $urandom_range(0, 4);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
			dog_cnt <= 0;
		end else if (dog_cnt >= DOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			dog_cnt <= dog_cnt + 1;
		end
	end

	initial begin
		logic [63:0] ca, cb, cr, ct, da, db;
		int          n_live;
		int          kind;

		meter_first = 1'b1;
		base_a      = '0;
		base_b      = '0;
		base_r      = '0;
		base_t      = '0;
		held_ratio  = '0;
		held_known  = 1'b0;
		held_db     = '0;
		held_dr     = '0;
		held_dt     = '0;

		// directed
		queue_sample(1'b0, ONES, ONES, ONES, ONES);
		queue_sample(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd1000, 64'd250, 64'd100, 64'd50);
		queue_sample(1'b1, 64'd2000, 64'd1250, 64'd100, 64'd50);
		queue_sample(1'b1, 64'd3000, 64'd5000, 64'd200, 64'd90);
		queue_sample(1'b1, 64'd3001, 64'd5000, 64'd200, 64'd90);
		queue_sample(1'b0, 64'd0, ONES, 64'd0, ONES);
		queue_sample(1'b1, 64'd10, 64'd5000, 64'd200, 64'd90);
		queue_sample(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
		queue_sample(1'b1, ONES, ONES >> 1, ONES, ONES);
		queue_sample(1'b1, ONES, ONES >> 1, ONES, ONES - 64'd5);
		queue_sample(1'b1, ONES, ONES, ONES, ONES);
		queue_sample(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
		queue_sample(1'b1, ONES, ONES - 64'd1, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd0, 64'd0, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd7, 64'd3, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd12, 64'd3, 64'd0, 64'd0);
		queue_sample(1'b1, 64'd12, 64'd9, 64'd4, 64'd2);

		// random: mostly rising counters, some wraps, ignored and zero-active items
		ca     = rand64() >> 8;
		cb     = ca >> 2;
		cr     = rand64() >> 8;
		ct     = rand64() >> 8;
		n_live = 0;
		while (n_live < N_LIVE) begin
			kind = $urandom_range(0, 99);
			if (kind < 7) begin
				queue_sample(1'b0, rand64(), rand64(), rand64(), rand64());
			end else begin
				if (kind < 14) begin
					ca = ($urandom_range(0, 1) == 0) ? rand64() : ca - rand_step();
					cb = ($urandom_range(0, 1) == 0) ? rand64() : cb - rand_step();
					cr = ($urandom_range(0, 2) == 0) ? 64'd0 : rand64();
					ct = ($urandom_range(0, 2) == 0) ? 64'd0 : ct - rand_step();
				end else begin
					da = (kind < 19) ? 64'd0 : rand_step();
					case ($urandom_range(0, 3))
						0: begin
							db = (da == 0) ? 64'd0 : rand64() % da;
						end
						1: begin
							db = da;
						end
						2: begin
							db = da + rand_step();
						end
						default: begin
							db = da >> $urandom_range(1, 16);
						end
					endcase
					ca = ca + da;
					cb = cb + db;
					cr = cr + rand_step();
					ct = ct + rand_step();
				end
				queue_sample(1'b1, ca, cb, cr, ct);
				n_live++;
			end
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		do begin
			@(negedge clk);
		end while (pending_samples.size() != 0 || sample_valid ||
			expected_results.size() != 0);
		repeat (DRAIN_CYC) @(negedge clk);

		if (err_cnt == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/cbrm_pkg.sv
rtl/cbrm_ctrl.sv
rtl/cbrm_datapath.sv
rtl/channel_busy_ratio_meter_core.sv
rtl/cbrm_checker.sv
tb/testbench.sv
